// File: sv/ddsa_pkg.sv
// Package for the decimal digit-serial ALU: item types, command and relation codes,
// digit constants. No dependencies.
package ddsa_pkg;

    localparam int DEFAULT_MAX_DIGITS = 31;

    // position counter: six bits, saturates at all ones
    localparam int              POS_W   = 6;
    localparam logic [POS_W-1:0] POS_SAT = '1;

    localparam logic [3:0] DIGIT_MAX = 4'd9;
    localparam logic [4:0] RADIX     = 5'd10;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_INC = 3'd2;
    localparam logic [2:0] CMD_CMP = 3'd3;
    localparam logic [2:0] CMD_PAL = 3'd4;

    localparam logic [1:0] REL_EQ = 2'd0;
    localparam logic [1:0] REL_LT = 2'd1;
    localparam logic [1:0] REL_GT = 2'd2;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] digit_a;
        logic [3:0] digit_b;
        logic       final_position;
    } t_in;

    typedef struct packed {
        logic [3:0] result_digit;
        logic       run_end;
        logic       borrow_out;
        logic       less;
        logic       greater;
        logic       equal;
        logic       palindrome;
        logic       overflow;
    } t_out;

    // per-item result of the digit step
    typedef struct packed {
        logic [3:0] digit;
        logic       carry;
        logic [1:0] rel;
        logic       emit;
        logic       two;
        logic       run_end;
        logic       brw;
        logic       lt;
        logic       gt;
        logic       eq;
        logic       is_pal;
    } t_step;

    function automatic logic [3:0] clamp_digit(input logic [3:0] d);
        return (d > DIGIT_MAX) ? DIGIT_MAX : d;
    endfunction

endpackage

// File: sv/decimal_digit_serial_alu.sv
// Top level of the decimal digit-serial ALU: state, output register, carry slot.
// Depends on ddsa_pkg, ddsa_alu, ddsa_pal.
//
// Decimal (BCD) add, subtract, increment, compare and palindrome test on two
// numbers that arrive one digit position per item, least significant first, the
// most significant position flagged by final_position. Digits above nine count
// as nine. Add, subtract and increment return one digit per item; add and
// increment return one more item (digit 1, run_end) when a carry leaves the top
// position. Compare and palindrome return a single item at the final position,
// as do the unused command codes. Subtract of a larger B from A returns the
// ten's complement digits and borrow_out on the last item. Positions past
// MAX_DIGITS are not stored and set overflow; the palindrome test then looks at
// the stored digits only. Rate: one item per clock unless the output stalls;
// an item that produces the extra carry item holds the input until its own
// digit item is taken. Results are registered: valid in the cycle after
// accept. The palindrome test is done on the fly with one digit comparator
// per store entry, so no end-of-number pass is needed.
module decimal_digit_serial_alu import ddsa_pkg::*; #(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_item,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_item
);

    localparam logic [POS_W:0] LP_MAX = (POS_W+1)'(MAX_DIGITS);

    // per-number state
    logic             r_carry;
    logic [1:0]       r_rel;
    logic [POS_W-1:0] r_pos;
    logic             r_ovf;

    // output register plus a slot for the trailing carry item
    logic             r_out_valid;
    t_out             r_out;
    logic             r_xtra;
    t_out             r_xtra_item;

    logic             acc_in;
    logic             out_take;
    logic [3:0]       a_c;
    logic [3:0]       b_c;
    logic             fin;
    logic             ovf_now;
    logic             pal_ok;
    t_step            step;
    t_out             n_out;
    t_out             n_xtra_item;

    assign o_in_stall = r_xtra | (r_out_valid & i_out_stall);
    assign acc_in     = i_in_valid & ~o_in_stall;
    assign out_take   = r_out_valid & ~i_out_stall;

    assign a_c = clamp_digit(i_in_item.digit_a);
    assign b_c = clamp_digit(i_in_item.digit_b);
    assign fin = i_in_item.final_position;

    // overflow seen by this item's results includes its own position
    assign ovf_now = r_ovf | ({1'b0, r_pos} >= LP_MAX);

    ddsa_alu u_alu (
        .i_cmd   (i_in_item.cmd),
        .i_a     (a_c),
        .i_b     (b_c),
        .i_fin   (fin),
        .i_first (r_pos == '0),
        .i_carry (r_carry),
        .i_rel   (r_rel),
        .o_step  (step)
    );

    ddsa_pal #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_pal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (acc_in),
        .i_digit (a_c),
        .i_pos   (r_pos),
        .i_final (fin),
        .o_pal   (pal_ok)
    );

    always_comb begin
        n_out.result_digit = step.digit;
        n_out.run_end      = step.run_end;
        n_out.borrow_out   = step.brw;
        n_out.less         = step.lt;
        n_out.greater      = step.gt;
        n_out.equal        = step.eq;
        n_out.palindrome   = step.is_pal & pal_ok;
        n_out.overflow     = ovf_now;

        n_xtra_item              = '0;
        n_xtra_item.result_digit = 4'd1;
        n_xtra_item.run_end      = 1'b1;
        n_xtra_item.overflow     = ovf_now;
    end

    // state: everything but the digit store returns to reset after a final position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= 1'b0;
            r_rel   <= REL_EQ;
            r_pos   <= '0;
            r_ovf   <= 1'b0;
        end else if (acc_in) begin
            if (fin) begin
                r_carry <= 1'b0;
                r_rel   <= REL_EQ;
                r_pos   <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_carry <= step.carry;
                r_rel   <= step.rel;
                if (r_pos == POS_SAT) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_ovf <= ovf_now;
                    r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

    // output side: accept only when the register is free or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_xtra      <= 1'b0;
        end else if (acc_in) begin
            r_out_valid <= step.emit;
            r_xtra      <= step.two;
        end else if (out_take) begin
            r_out_valid <= r_xtra;
            r_xtra      <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_out       <= n_out;
            r_xtra_item <= n_xtra_item;
        end else if (out_take && r_xtra) begin
            r_out <= r_xtra_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // carry slot only fills behind a full output register
    a_xtra_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_xtra |-> r_out_valid)
        else $error("carry item pending with empty output register");

    // a pending carry item blocks new input
    a_xtra_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_xtra |-> o_in_stall)
        else $error("input accepted while carry item pending");

    // a final position closes the number
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && fin) |=> (r_pos == '0 && !r_carry && !r_ovf && r_rel == REL_EQ))
        else $error("number state not cleared after final position");

    // status flags other than overflow only ride on the last item of a number
    a_flags_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.run_end) |->
            !(o_out_item.less || o_out_item.greater || o_out_item.equal ||
              o_out_item.palindrome || o_out_item.borrow_out))
        else $error("status flag set on a non-final result item");

    // a delivered digit item with a carry pending must be followed by the trailing carry digit
    a_xtra_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_xtra && out_take) |=> (r_out_valid && !r_xtra && o_out_item.run_end))
        else $error("trailing carry item lost");

endmodule

// File: sv/ddsa_alu.sv
// Combinational digit step: add, subtract, increment, compare per position, and end-of-number flags for every command.
// Depends on ddsa_pkg.
module ddsa_alu import ddsa_pkg::*; (
    input  logic [2:0] i_cmd,
    input  logic [3:0] i_a,
    input  logic [3:0] i_b,
    input  logic       i_fin,
    input  logic       i_first,
    input  logic       i_carry,
    input  logic [1:0] i_rel,
    output t_step      o_step
);

    logic [4:0] sum;
    logic [4:0] sub;
    logic       cin;
    logic [1:0] rel;

    always_comb begin
        o_step = '0;
        sum    = '0;
        sub    = '0;
        cin    = i_first ? 1'b0 : i_carry;
        rel    = i_first ? REL_EQ : i_rel;
        o_step.carry = i_carry;
        o_step.rel   = i_rel;
        unique case (i_cmd) inside
            CMD_ADD, CMD_INC: begin
                if (i_cmd == CMD_INC) begin
                    sum = {1'b0, i_a} + {4'd0, i_first | i_carry};
                end else begin
                    sum = {1'b0, i_a} + {1'b0, i_b} + {4'd0, cin};
                end
                o_step.carry   = (sum >= RADIX);
                o_step.digit   = o_step.carry ? 4'(sum - RADIX) : sum[3:0];
                o_step.emit    = 1'b1;
                o_step.two     = i_fin & o_step.carry;
                o_step.run_end = i_fin & ~o_step.carry;
            end
            CMD_SUB: begin
                sub = {1'b0, i_b} + {4'd0, cin};
                if ({1'b0, i_a} >= sub) begin
                    o_step.digit = 4'({1'b0, i_a} - sub);
                    o_step.carry = 1'b0;
                end else begin
                    o_step.digit = 4'({1'b0, i_a} + RADIX - sub);
                    o_step.carry = 1'b1;
                end
                o_step.emit    = 1'b1;
                o_step.run_end = i_fin;
                o_step.brw     = i_fin & o_step.carry;
            end
            CMD_CMP: begin
                if (i_a < i_b) begin
                    rel = REL_LT;
                end else if (i_a > i_b) begin
                    rel = REL_GT;
                end
                o_step.rel     = rel;
                o_step.emit    = i_fin;
                o_step.run_end = i_fin;
                o_step.lt      = i_fin & (rel == REL_LT);
                o_step.gt      = i_fin & (rel == REL_GT);
                o_step.eq      = i_fin & (rel == REL_EQ);
            end
            CMD_PAL: begin
                o_step.emit    = i_fin;
                o_step.run_end = i_fin;
                o_step.is_pal  = i_fin;
            end
            default: begin
                o_step.emit    = i_fin;
                o_step.run_end = i_fin;
            end
        endcase
    end

endmodule

// File: sv/ddsa_pal.sv
// Digit store and running mirror flags for the palindrome test.
// Depends on ddsa_pkg.
module ddsa_pal import ddsa_pkg::*; #(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [3:0]       i_digit,
    input  logic [POS_W-1:0] i_pos,
    input  logic             i_final,
    output logic             o_pal
);

    localparam int               IDX_W = $clog2(MAX_DIGITS);
    localparam logic [POS_W:0]   LP_MAX = (POS_W+1)'(MAX_DIGITS);
    localparam logic [POS_W:0]   LP_LAST = (POS_W+1)'(MAX_DIGITS - 1);

    // r_mir[q]: all pairs seen so far agree for length q + pos + 1
    logic [MAX_DIGITS-1:0] r_mir;
    logic [MAX_DIGITS-1:0] keep;
    logic [3:0]            r_store [MAX_DIGITS];
    logic                  past_store;
    logic                  at_last;

    assign past_store = ({1'b0, i_pos} >= LP_MAX);
    assign at_last    = ({1'b0, i_pos} >= LP_LAST);

    always_comb begin
        for (int q = 0; q < MAX_DIGITS; q++) begin
            keep[q] = r_mir[q] &
                      ((POS_W'(q) < i_pos) ? (i_digit == r_store[q]) : 1'b1);
        end
    end

    // beyond the store, the length is clamped: the flags froze at the last entry
    assign o_pal = past_store ? (r_mir[0] & (r_store[MAX_DIGITS-1] == r_store[0]))
                              : keep[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mir <= '1;
        end else if (i_en) begin
            if (i_final) begin
                r_mir <= '1;
            end else if (!at_last) begin
                r_mir <= {1'b1, keep[MAX_DIGITS-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && !past_store) begin
            r_store[i_pos[IDX_W-1:0]] <= i_digit;
        end
    end

endmodule

// File: tb/ddsa_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the decimal digit-serial ALU bench: per-position predictor and the
// queue of due result items. Depends on ddsa_pkg.
package ddsa_tb_pkg;
    import ddsa_pkg::*;

    // unused command codes, driven to check the default path
    localparam logic [2:0] CMD_RSV5 = 3'd5;
    localparam logic [2:0] CMD_RSV7 = 3'd7;

    localparam int STORE_DEPTH = DEFAULT_MAX_DIGITS;

    class t_ddsa_scoreboard;
        logic             carry;
        logic [1:0]       rel;
        logic [POS_W-1:0] pos;
        logic             ovf;
        logic [3:0]       store [STORE_DEPTH];
        t_out             due [$];
        int               errors;
        int               checked;
        int               ovf_seen;

        function new();
            carry    = 1'b0;
            rel      = REL_EQ;
            pos      = '0;
            ovf      = 1'b0;
            errors   = 0;
            checked  = 0;
            ovf_seen = 0;
        endfunction

        function logic [3:0] sat9(input logic [3:0] d);
            return (d > 4'd9) ? 4'd9 : d;
        endfunction

        // stored digits of A read the same both ways, over at most the store depth
        function logic mirror_ok(input int len);
            int k;
            if (len > STORE_DEPTH) len = STORE_DEPTH;
            for (k = 0; k < len / 2; k++)
                if (store[k] != store[len - 1 - k]) return 1'b0;
            return 1'b1;
        endfunction

        // one accepted position: update the shadow state, queue its result items
        function void take_position(input t_in it);
            logic [3:0]       a;
            logic [3:0]       b;
            logic [4:0]       s;
            logic             cin;
            logic             fin;
            logic [POS_W-1:0] p;
            t_out             r;
            a   = sat9(it.digit_a);
            b   = sat9(it.digit_b);
            fin = it.final_position;
            p   = pos;
            cin = carry;
            r   = '0;
            if (p < STORE_DEPTH) store[p] = a;
            else ovf = 1'b1;
            r.overflow = ovf;
            case (it.cmd)
                CMD_ADD, CMD_INC: begin
                    if (it.cmd == CMD_INC) begin
                        if (p == 0) cin = 1'b1;
                        s = {1'b0, a} + cin;
                    end else begin
                        if (p == 0) cin = 1'b0;
                        s = {1'b0, a} + b + cin;
                    end
                    carry = (s >= 5'd10);
                    r.result_digit = carry ? 4'(s - 5'd10) : s[3:0];
                    if (fin && carry) begin
                        // top carry leaves as an extra digit 1
                        due.push_back(r);
                        r.result_digit = 4'd1;
                        r.run_end      = 1'b1;
                        due.push_back(r);
                    end else begin
                        r.run_end = fin;
                        due.push_back(r);
                    end
                end
                CMD_SUB: begin
                    if (p == 0) cin = 1'b0;
                    if ({1'b0, a} >= {1'b0, b} + cin) begin
                        s     = {1'b0, a} - b - cin;
                        carry = 1'b0;
                    end else begin
                        s     = {1'b0, a} + 5'd10 - b - cin;
                        carry = 1'b1;
                    end
                    r.result_digit = s[3:0];
                    r.run_end      = fin;
                    r.borrow_out   = fin & carry;
                    due.push_back(r);
                end
                CMD_CMP: begin
                    if (p == 0) rel = REL_EQ;
                    if (a < b) rel = REL_LT;
                    else if (a > b) rel = REL_GT;
                    if (fin) begin
                        r.run_end = 1'b1;
                        r.less    = (rel == REL_LT);
                        r.greater = (rel == REL_GT);
                        r.equal   = (rel == REL_EQ);
                        due.push_back(r);
                    end
                end
                CMD_PAL: begin
                    if (fin) begin
                        r.run_end    = 1'b1;
                        r.palindrome = mirror_ok(int'(p) + 1);
                        due.push_back(r);
                    end
                end
                default: begin
                    if (fin) begin
                        r.run_end = 1'b1;
                        due.push_back(r);
                    end
                end
            endcase
            if (fin) begin
                carry = 1'b0;
                rel   = REL_EQ;
                pos   = '0;
                ovf   = 1'b0;
            end else if (p == POS_SAT) begin
                ovf = 1'b1;
            end else begin
                pos = p + 1'b1;
            end
        endfunction

        function void check_field(input string name, input logic [3:0] want,
                                  input logic [3:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input t_out got);
            t_out want;
            if (due.size() == 0) begin
                $error("result item with nothing due: %p", got);
                errors++;
                return;
            end
            want = due.pop_front();
            checked++;
            if (want.overflow) ovf_seen++;
            check_field("result_digit", want.result_digit, got.result_digit);
            check_field("run_end",      want.run_end,      got.run_end);
            check_field("borrow_out",   want.borrow_out,   got.borrow_out);
            check_field("less",         want.less,         got.less);
            check_field("greater",      want.greater,      got.greater);
            check_field("equal",        want.equal,        got.equal);
            check_field("palindrome",   want.palindrome,   got.palindrome);
            check_field("overflow",     want.overflow,     got.overflow);
        endfunction
    endclass

endpackage

// File: tb/tb_decimal_digit_serial_alu.sv
`timescale 1ns / 100ps
// Bench top for decimal_digit_serial_alu: clock, reset, bursty digit driver, stalling
// result sink and run control. Depends on ddsa_pkg, ddsa_tb_pkg and the RTL.
module tb_decimal_digit_serial_alu;
    import ddsa_pkg::*;
    import ddsa_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int CYCLE_LIMIT  = 400000;
    // sender pauses for a full drain this often (in items)
    localparam int DRAIN_EVERY  = 500;

    // digit patterns for a generated number
    typedef enum int {SHAPE_RANDOM, SHAPE_EQUAL, SHAPE_MIRROR, SHAPE_NINES} t_shape;
    // result sink behavior, chosen anew at random when its hold counter runs out
    typedef enum logic [1:0] {SINK_FREE, SINK_LIGHT, SINK_HEAVY, SINK_BEAT} t_sink_mode;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_in  in_item   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_item;

    t_ddsa_scoreboard sb;
    int         cycles       = 0;
    int         burst_left   = 0;
    int         items_sent   = 0;
    int         numbers_sent = 0;
    int         long_numbers = 0;
    t_sink_mode sink_mode    = SINK_FREE;
    int         sink_left    = 0;

    decimal_digit_serial_alu u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Both handshakes are sampled here at the edge, so everything read is the
    // value from before the edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) sb.take_position(in_item);
            if (out_valid && !out_stall) sb.check_result(out_item);
        end
    end

    // Result sink: free running, light or heavy random stall, or a fixed beat.
    always @(posedge clk) begin
        if (sink_left == 0) begin
            sink_mode <= t_sink_mode'($urandom_range(0, 3));
            sink_left <= $urandom_range(16, 120);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            SINK_FREE:  out_stall <= 1'b0;
            SINK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            SINK_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:    out_stall <= ((cycles % 5) < 2);
        endcase
    end

    // Watchdog.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycles,
                     sb.due.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [3:0] rand_digit();
        // mostly decimal digits, now and then a code above nine
        if ($urandom_range(0, 9) == 0) return 4'($urandom_range(10, 15));
        return 4'($urandom_range(0, 9));
    endfunction

    // Present one item; bursts of random length with random gaps in front.
    task automatic send_item(input t_in it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic push_position(input logic [2:0] cmd, input logic [3:0] a,
                                 input logic [3:0] b, input logic fin);
        t_in it;
        it.cmd            = cmd;
        it.digit_a        = a;
        it.digit_b        = b;
        it.final_position = fin;
        send_item(it);
    endtask

    // Hold off the sender until every due result has come back. The loop waits on the
    // clock before its first check, so valid is never dropped and raised in one step.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (sb.due.size() != 0);
    endtask

    // One number pair, least significant position first. A few positions of a
    // number get a random command to exercise mixed-command numbers.
    task automatic send_number(input logic [2:0] op, input int len, input t_shape shape);
        logic [3:0] da [0:79];
        logic [3:0] db [0:79];
        logic [2:0] cmd;
        int         span;
        int         k;
        for (k = 0; k < len; k++) begin
            da[k] = rand_digit();
            db[k] = rand_digit();
        end
        span = (len > STORE_DEPTH) ? STORE_DEPTH : len;
        case (shape)
            SHAPE_EQUAL:  for (k = 0; k < len; k++) db[k] = da[k];
            // mirrored over the stored part only, which is what gets checked
            SHAPE_MIRROR: for (k = 0; k < span / 2; k++) da[span - 1 - k] = da[k];
            SHAPE_NINES:  for (k = 0; k < len; k++) begin
                da[k] = 4'd9;
                if ($urandom_range(0, 1) == 0) db[k] = 4'd9;
            end
            default: ;
        endcase
        for (k = 0; k < len; k++) begin
            cmd = op;
            if ($urandom_range(0, 29) == 0) cmd = 3'($urandom_range(CMD_ADD, CMD_RSV7));
            push_position(cmd, da[k], db[k], k == len - 1);
        end
        numbers_sent++;
        if (len > STORE_DEPTH) long_numbers++;
    endtask

    task automatic run_directed();
        // largest sum: 9 + 9 leaves a top carry
        push_position(CMD_ADD, 4'd9, 4'd9, 1'b1);
        // zero sum
        push_position(CMD_ADD, 4'd0, 4'd0, 1'b1);
        // codes above nine count as nine
        push_position(CMD_ADD, 4'd15, 4'd0, 1'b0);
        push_position(CMD_ADD, 4'd0, 4'd15, 1'b1);
        // negative difference, one digit: 3 - 7
        push_position(CMD_SUB, 4'd3, 4'd7, 1'b1);
        // borrow ripple: 100 - 1
        push_position(CMD_SUB, 4'd0, 4'd1, 1'b0);
        push_position(CMD_SUB, 4'd0, 4'd0, 1'b0);
        push_position(CMD_SUB, 4'd1, 4'd0, 1'b1);
        // increment starts with a carry in: 9 wraps, 5 does not
        push_position(CMD_INC, 4'd9, 4'd3, 1'b1);
        push_position(CMD_INC, 4'd5, 4'd9, 1'b1);
        // compare: top digit decides greater over a lower smaller digit
        push_position(CMD_CMP, 4'd3, 4'd9, 1'b0);
        push_position(CMD_CMP, 4'd8, 4'd2, 1'b1);
        push_position(CMD_CMP, 4'd4, 4'd4, 1'b1);
        push_position(CMD_CMP, 4'd9, 4'd0, 1'b0);
        push_position(CMD_CMP, 4'd0, 4'd1, 1'b1);
        // palindrome true, then false
        push_position(CMD_PAL, 4'd1, 4'd0, 1'b0);
        push_position(CMD_PAL, 4'd2, 4'd0, 1'b0);
        push_position(CMD_PAL, 4'd1, 4'd0, 1'b1);
        push_position(CMD_PAL, 4'd1, 4'd0, 1'b0);
        push_position(CMD_PAL, 4'd2, 4'd0, 1'b1);
        // unused command codes
        push_position(CMD_RSV5, 4'd7, 4'd2, 1'b1);
        push_position(CMD_RSV7, 4'd15, 4'd15, 1'b0);
        push_position(CMD_RSV7, 4'd6, 4'd8, 1'b1);
        // mixed commands inside one number
        push_position(CMD_ADD, 4'd8, 4'd7, 1'b0);
        push_position(CMD_SUB, 4'd2, 4'd5, 1'b1);
    endtask

    task automatic run_random();
        logic [2:0] op;
        int         first_item;
        int         last_drain;
        int         len;
        int         pick;
        first_item = items_sent;
        last_drain = items_sent;
        // store overflow: palindrome over the stored part, and a run long
        // enough to saturate the position count
        send_number(CMD_PAL, 40, SHAPE_MIRROR);
        send_number(CMD_PAL, 33, SHAPE_RANDOM);
        send_number(CMD_ADD, 66, SHAPE_NINES);
        send_number(CMD_CMP, 64, SHAPE_EQUAL);
        while (items_sent - first_item < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) < 17) op = 3'($urandom_range(CMD_ADD, CMD_PAL));
            else op = 3'($urandom_range(CMD_RSV5, CMD_RSV7));
            pick = $urandom_range(0, 99);
            if (pick < 70) len = $urandom_range(1, 6);
            else if (pick < 97) len = $urandom_range(7, STORE_DEPTH);
            else len = $urandom_range(STORE_DEPTH + 1, 70);
            send_number(op, len, t_shape'($urandom_range(0, 3)));
            if (items_sent - last_drain >= DRAIN_EVERY) begin
                drain();
                last_drain = items_sent;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        drain();
        run_random();
        drain();
        // let any stray result item show up
        repeat (10) @(posedge clk);
        if (sb.due.size() != 0) begin
            $error("%0d result items never arrived", sb.due.size());
            sb.errors++;
        end
        $display("covered %0d numbers in %0d positions (%0d past the digit store)",
                 numbers_sent, items_sent, long_numbers);
        $display("checked %0d result items, %0d with overflow, %0d mismatches",
                 sb.checked, sb.ovf_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: decimal_digit_serial_alu.f
sv/ddsa_pkg.sv
sv/ddsa_alu.sv
sv/ddsa_pal.sv
sv/decimal_digit_serial_alu.sv
tb/ddsa_tb_pkg.sv
tb/tb_decimal_digit_serial_alu.sv
